>>> rtl/median_filter_2d_replicate_core_defines.svh
// Assertion macros shared by the median filter RTL.
// Needs a clock named clk and an active-low reset named rst_n in scope.
`ifndef MEDIAN_FILTER_2D_REPLICATE_CORE_DEFINES_SVH
`define MEDIAN_FILTER_2D_REPLICATE_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define MF2_CHK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define MF2_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> rtl/mf2d_pkg.sv
// Shared types and constants of the median filter.
// No dependencies.
package mf2d_pkg;

  localparam int PIX_W      = 8;
  localparam int ROW_W      = 12;
  localparam int HGT_W      = 13;
  localparam int WIN_W      = 4;
  localparam int WID_W      = 11;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;
  localparam int MAX_HEIGHT = 4096;
  localparam int SZ_LIMIT   = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_WINDOW = 2'd0,
    REG_WIDTH  = 2'd1,
    REG_HEIGHT = 2'd2,
    REG_NONE   = 2'd3
  } cfg_reg_t;

  typedef enum logic {
    KIND_PIXEL = 1'b0,
    KIND_DRAIN = 1'b1
  } item_kind_t;

endpackage

>>> rtl/mf2d_if.sv
// Stream interfaces of the median filter: pixel input and result output.
// Depends on mf2d_pkg.
interface mf2d_in_if import mf2d_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             kind;
  logic [PIX_W-1:0] pixel_in;
  modport source (output valid, output kind, output pixel_in, input ready);
  modport sink   (input valid, input kind, input pixel_in, output ready);
endinterface

interface mf2d_out_if import mf2d_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             row_last;
  logic             frame_last;
  modport source (output valid, output pixel_out, output row_last, output frame_last,
                  input ready);
  modport sink   (input valid, input pixel_out, input row_last, input frame_last,
                  output ready);
endinterface

>>> rtl/mf2d_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mf2d_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

>>> rtl/median_filter_2d_replicate_core.sv
// Square median filter (window 1x1 to 9x9, edge pixels replicated) over one
// 8-bit channel in raster order. Each accepted pixel is written to a line store
// of MAX_WINDOW rows and then yields every output whose window is complete, at
// most half+1 of them; after the last pixel, each drain transaction yields one
// pending output. A stored pixel or a drain with frame input complete, when it
// has nothing to emit, holds the input off through the check state; a pixel
// after frame input or an early drain is dropped. The median is chosen
// most-significant bit first: each of the 8 bit passes reads the whole window
// through the single read port of the line store into one comparator, then the
// result is presented until the output takes it (any output stall holds the
// filter) and the next one is checked for. No clearing pass after reset;
// unwritten line store entries are never read. Configuration writes restart
// the frame.
module median_filter_2d_replicate_core
  import mf2d_pkg::*;
#(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_WINDOW = 9
) (
  input  logic                  clk,
  input  logic                  rst_n,
  mf2d_in_if.sink               in_s,
  mf2d_out_if.source            out_s,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);
  `include "median_filter_2d_replicate_core_defines.svh"

  localparam int CW      = $clog2(MAX_WIDTH + 1);
  localparam int SW      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int DEPTH   = MAX_WINDOW * MAX_WIDTH;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_RAW = (MAX_WINDOW - 1) | 1;
  localparam int WIN_CAP = (CAP_RAW < SZ_LIMIT) ? CAP_RAW : SZ_LIMIT;

  typedef enum logic [6:0] {
    ST_IDLE   = 7'b0000001,
    ST_CHECK  = 7'b0000010,
    ST_PREP   = 7'b0000100,
    ST_SCAN   = 7'b0001000,
    ST_WAITD  = 7'b0010000,
    ST_DECIDE = 7'b0100000,
    ST_OUT    = 7'b1000000
  } state_t;

  // Configuration registers
  logic [WIN_W-1:0] win_r, win_nxt;
  logic [WID_W-1:0] wid_r, wid_nxt;
  logic [HGT_W-1:0] hgt_r, hgt_nxt;

  // Frame position
  logic [HGT_W-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0]    in_col_r, in_col_nxt;
  logic [SW-1:0]    in_slot_r, in_slot_nxt;
  logic             in_done_r, in_done_nxt;
  logic [ROW_W-1:0] out_row_r, out_row_nxt;
  logic [CW-1:0]    out_col_r, out_col_nxt;
  logic [SW-1:0]    out_slot_r, out_slot_nxt;

  // Sequencer
  state_t           state_r, state_nxt;
  logic [2:0]       emit_cnt_r, emit_cnt_nxt;
  logic [2:0]       limit_r, limit_nxt;
  logic [3:0]       dy_r, dy_nxt;
  logic [3:0]       dx_r, dx_nxt;
  logic signed [ROW_W+1:0] row_raw_r, row_raw_nxt;
  logic signed [CW+1:0]    col_raw_r, col_raw_nxt;
  logic [SW-1:0]    slot_r, slot_nxt;
  logic [2:0]       bit_r, bit_nxt;
  logic [PIX_W-1:0] pref_r, pref_nxt;
  logic [6:0]       cnt_r, cnt_nxt;
  logic             rd_v_r;

  // Result register
  logic             out_valid_r, out_valid_nxt;
  logic [PIX_W-1:0] out_pix_r, out_pix_nxt;
  logic             out_rl_r, out_rl_nxt;
  logic             out_fl_r, out_fl_nxt;

  // Effective configuration
  logic [3:0]       sz_a, sz_b, sz_c, sz;
  logic [2:0]       half;
  logic [6:0]       n_win, k_win;
  logic [13:0]      w_wide;
  logic [CW-1:0]    w_m1;
  logic [HGT_W-1:0] h_eff;
  logic [ROW_W-1:0] h_m1;

  always_comb begin
    sz_a   = (win_r == '0) ? 4'd1 : win_r;
    sz_b   = sz_a | 4'd1;
    sz_c   = (sz_b > 4'(SZ_LIMIT)) ? 4'(SZ_LIMIT) : sz_b;
    sz     = (sz_c > 4'(WIN_CAP)) ? 4'(WIN_CAP) : sz_c;
    half   = sz[3:1];
    n_win  = 7'(sz) * 7'(sz);
    k_win  = n_win >> 1;
    w_wide = (wid_r == '0) ? 14'd1 :
             (({3'b0, wid_r} > 14'(MAX_WIDTH)) ? 14'(MAX_WIDTH) : {3'b0, wid_r});
    w_m1   = CW'(w_wide - 14'd1);
    h_eff  = (hgt_r == '0) ? 13'd1 :
             ((hgt_r > 13'(MAX_HEIGHT)) ? 13'(MAX_HEIGHT) : hgt_r);
    h_m1   = ROW_W'(h_eff - 13'd1);
  end

  // Readiness of the next output: its clamped window corner has arrived.
  logic [ROW_W:0] nr_sum;
  logic [ROW_W-1:0] nr;
  logic [CW:0]    nc_sum;
  logic [CW-1:0]  nc;
  logic           pend_ok;

  always_comb begin
    nr_sum  = {1'b0, out_row_r} + (ROW_W+1)'(half);
    nr      = (nr_sum > {1'b0, h_m1}) ? h_m1 : nr_sum[ROW_W-1:0];
    nc_sum  = {1'b0, out_col_r} + (CW+1)'(half);
    nc      = (nc_sum > {1'b0, w_m1}) ? w_m1 : nc_sum[CW-1:0];
    pend_ok = in_done_r || ({1'b0, nr} < in_row_r) ||
              (({1'b0, nr} == in_row_r) && (nc < in_col_r));
  end

  // Window walk: clamped column and line store addresses
  logic [CW-1:0]    col_cl;
  logic [PIX_W-1:0] rd_data;
  logic [PIX_W-1:0] thr;
  logic [AW-1:0]    raddr, waddr;
  logic [SW:0]      slot_up;
  logic [SW-1:0]    slot0;
  logic signed [ROW_W+1:0] row_next;
  logic             accept, re;

  always_comb begin
    if (col_raw_r < 0) begin
      col_cl = '0;
    end else if (col_raw_r > $signed({2'b00, w_m1})) begin
      col_cl = w_m1;
    end else begin
      col_cl = col_raw_r[CW-1:0];
    end
    raddr = AW'(AW'(slot_r) * AW'(MAX_WIDTH) + AW'(col_cl));
    waddr = AW'(AW'(in_slot_r) * AW'(MAX_WIDTH) + AW'(in_col_r));
    thr   = pref_r | (PIX_W'(1) << bit_r);
    // Slot of the top window row: the output row's slot moved back by half
    slot_up = ({1'b0, out_slot_r} >= (SW+1)'(half)) ?
              ({1'b0, out_slot_r} - (SW+1)'(half)) :
              ({1'b0, out_slot_r} + (SW+1)'(MAX_WINDOW) - (SW+1)'(half));
    slot0   = (out_row_r >= ROW_W'(half)) ? slot_up[SW-1:0] : '0;
    row_next = row_raw_r + $signed((ROW_W+2)'(1));
    accept  = in_s.valid && in_s.ready;
    re      = (state_r == ST_SCAN);
  end

  mf2d_ram #(
    .WIDTH (PIX_W),
    .DEPTH (DEPTH)
  ) u_line_store (
    .clk   (clk),
    .we    (accept && (in_s.kind == KIND_PIXEL) && !in_done_r),
    .waddr (waddr),
    .wdata (in_s.pixel_in),
    .re    (re),
    .raddr (raddr),
    .rdata (rd_data)
  );

  assign in_s.ready       = (state_r == ST_IDLE);
  assign out_s.valid      = out_valid_r;
  assign out_s.pixel_out  = out_pix_r;
  assign out_s.row_last   = out_rl_r;
  assign out_s.frame_last = out_fl_r;

  always_comb begin
    win_nxt       = win_r;
    wid_nxt       = wid_r;
    hgt_nxt       = hgt_r;
    in_row_nxt    = in_row_r;
    in_col_nxt    = in_col_r;
    in_slot_nxt   = in_slot_r;
    in_done_nxt   = in_done_r;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_slot_nxt  = out_slot_r;
    state_nxt     = state_r;
    emit_cnt_nxt  = emit_cnt_r;
    limit_nxt     = limit_r;
    dy_nxt        = dy_r;
    dx_nxt        = dx_r;
    row_raw_nxt   = row_raw_r;
    col_raw_nxt   = col_raw_r;
    slot_nxt      = slot_r;
    bit_nxt       = bit_r;
    pref_nxt      = pref_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_pix_nxt   = out_pix_r;
    out_rl_nxt    = out_rl_r;
    out_fl_nxt    = out_fl_r;

    // Count window samples below the threshold in the cycle after each read
    if (rd_v_r && (rd_data < thr)) begin
      cnt_nxt = cnt_r + 7'd1;
    end

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          emit_cnt_nxt = '0;
          if (in_s.kind == KIND_PIXEL) begin
            if (!in_done_r) begin
              // Store the pixel, advance the input position
              limit_nxt = 3'(half) + 3'd1;
              state_nxt = ST_CHECK;
              if (in_col_r == w_m1) begin
                in_col_nxt  = '0;
                in_row_nxt  = in_row_r + 13'd1;
                in_slot_nxt = (in_slot_r == SW'(MAX_WINDOW - 1)) ? '0 : in_slot_r + SW'(1);
                if (in_row_r == {1'b0, h_m1}) begin
                  in_done_nxt = 1'b1;
                end
              end else begin
                in_col_nxt = in_col_r + CW'(1);
              end
            end
          end else if (in_done_r) begin
            limit_nxt = 3'd1;
            state_nxt = ST_CHECK;
          end
        end
      end
      ST_CHECK: begin
        if ((emit_cnt_r < limit_r) && pend_ok) begin
          bit_nxt   = 3'(PIX_W - 1);
          pref_nxt  = '0;
          state_nxt = ST_PREP;
        end else begin
          state_nxt = ST_IDLE;
        end
      end
      ST_PREP: begin
        // Set the walk to the top-left corner of the window
        dy_nxt      = '0;
        dx_nxt      = '0;
        row_raw_nxt = $signed({2'b00, out_row_r}) - $signed({11'b0, half});
        col_raw_nxt = $signed({2'b00, out_col_r}) - $signed((CW+2)'(half));
        slot_nxt    = slot0;
        cnt_nxt     = '0;
        state_nxt   = ST_SCAN;
      end
      ST_SCAN: begin
        if (dx_r == sz - 4'd1) begin
          dx_nxt      = '0;
          col_raw_nxt = $signed({2'b00, out_col_r}) - $signed((CW+2)'(half));
          dy_nxt      = dy_r + 4'd1;
          row_raw_nxt = row_next;
          // Step the row slot only while the next row is inside the frame
          if ((row_next > 0) && (row_next <= $signed({2'b00, h_m1}))) begin
            slot_nxt = (slot_r == SW'(MAX_WINDOW - 1)) ? '0 : slot_r + SW'(1);
          end
          if (dy_r == sz - 4'd1) begin
            state_nxt = ST_WAITD;
          end
        end else begin
          dx_nxt      = dx_r + 4'd1;
          col_raw_nxt = col_raw_r + $signed((CW+2)'(1));
        end
      end
      ST_WAITD: begin
        state_nxt = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (cnt_r <= k_win) begin
          pref_nxt = thr;
        end
        if (bit_r == '0) begin
          out_valid_nxt = 1'b1;
          out_pix_nxt   = (cnt_r <= k_win) ? thr : pref_r;
          out_rl_nxt    = (out_col_r == w_m1);
          out_fl_nxt    = (out_col_r == w_m1) && (out_row_r == h_m1);
          emit_cnt_nxt  = emit_cnt_r + 3'd1;
          state_nxt     = ST_OUT;
          if (out_col_r == w_m1) begin
            out_col_nxt = '0;
            if (out_row_r == h_m1) begin
              // Frame complete: restart every position
              out_row_nxt  = '0;
              out_slot_nxt = '0;
              in_row_nxt   = '0;
              in_col_nxt   = '0;
              in_slot_nxt  = '0;
              in_done_nxt  = 1'b0;
            end else begin
              out_row_nxt  = out_row_r + ROW_W'(1);
              out_slot_nxt = (out_slot_r == SW'(MAX_WINDOW - 1)) ? '0 : out_slot_r + SW'(1);
            end
          end else begin
            out_col_nxt = out_col_r + CW'(1);
          end
        end else begin
          bit_nxt   = bit_r - 3'd1;
          state_nxt = ST_PREP;
        end
      end
      ST_OUT: begin
        if (out_s.ready) begin
          out_valid_nxt = 1'b0;
          state_nxt     = ST_CHECK;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // Any register write restarts the frame; the line store is kept
    if (cfg_we) begin
      case (cfg_idx)
        REG_WINDOW: win_nxt = cfg_wdata[WIN_W-1:0];
        REG_WIDTH:  wid_nxt = cfg_wdata[WID_W-1:0];
        REG_HEIGHT: hgt_nxt = cfg_wdata[HGT_W-1:0];
        default: ;
      endcase
      if (cfg_idx != REG_NONE) begin
        in_row_nxt   = '0;
        in_col_nxt   = '0;
        in_slot_nxt  = '0;
        in_done_nxt  = 1'b0;
        out_row_nxt  = '0;
        out_col_nxt  = '0;
        out_slot_nxt = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= 4'd3;
      wid_r       <= 11'd1024;
      hgt_r       <= 13'd1024;
      in_row_r    <= '0;
      in_col_r    <= '0;
      in_slot_r   <= '0;
      in_done_r   <= 1'b0;
      out_row_r   <= '0;
      out_col_r   <= '0;
      out_slot_r  <= '0;
      state_r     <= ST_IDLE;
      emit_cnt_r  <= '0;
      limit_r     <= '0;
      rd_v_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      win_r       <= win_nxt;
      wid_r       <= wid_nxt;
      hgt_r       <= hgt_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      in_slot_r   <= in_slot_nxt;
      in_done_r   <= in_done_nxt;
      out_row_r   <= out_row_nxt;
      out_col_r   <= out_col_nxt;
      out_slot_r  <= out_slot_nxt;
      state_r     <= state_nxt;
      emit_cnt_r  <= emit_cnt_nxt;
      limit_r     <= limit_nxt;
      rd_v_r      <= re;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers, no reset needed
  always_ff @(posedge clk) begin
    dy_r      <= dy_nxt;
    dx_r      <= dx_nxt;
    row_raw_r <= row_raw_nxt;
    col_raw_r <= col_raw_nxt;
    slot_r    <= slot_nxt;
    bit_r     <= bit_nxt;
    pref_r    <= pref_nxt;
    cnt_r     <= cnt_nxt;
    out_pix_r <= out_pix_nxt;
    out_rl_r  <= out_rl_nxt;
    out_fl_r  <= out_fl_nxt;
  end

  `MF2_CHK(a_out_only_in_out, out_valid_r |-> (state_r == ST_OUT), "result shown outside output state")
  `MF2_CHK(a_emit_bound, (state_r != ST_IDLE) |-> (emit_cnt_r <= limit_r), "too many results for one transaction")
  `MF2_CHK(a_cnt_bound, (state_r == ST_DECIDE) |-> (cnt_r <= n_win), "sample count exceeds window")
  `MF2_NEVER(a_frame_row, out_valid_r && out_fl_r && !out_rl_r, "frame end without row end")
  `MF2_CHK(a_scan_done, (state_r == ST_WAITD) |-> $past(state_r == ST_SCAN), "window walk cut short")
endmodule
